// ===== hw/rtl/mva_pkg.sv =====
// ----------------------------------------------------------------------------
// mva_pkg
// Shared types and codes for the voice allocator: decoded operations, result
// actions and the word passed from the decoder to the voice sequencer.
// ----------------------------------------------------------------------------
package mva_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [3:0] NIB_NOTE_OFF = 4'h8;
    localparam logic [3:0] NIB_NOTE_ON  = 4'h9;
    localparam logic [3:0] NIB_CTRL     = 4'hb;
    localparam logic [7:0] CC_SOUND_OFF = 8'd120;
    localparam logic [7:0] CC_NOTES_OFF = 8'd123;

    typedef enum logic [1:0] {
        CMD_MIDI     = 2'd0,
        CMD_FINISHED = 2'd1,
        CMD_LEVEL    = 2'd2,
        CMD_UNUSED   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        OP_NONE     = 3'd0,
        OP_NOTE_OFF = 3'd1,
        OP_NOTE_ON  = 3'd2,
        OP_STOP_ALL = 3'd3,
        OP_FINISHED = 3'd4,
        OP_LEVEL    = 3'd5
    } t_op;

    typedef enum logic [2:0] {
        ACT_NONE     = 3'd0,
        ACT_START    = 3'd1,
        ACT_RELEASE  = 3'd2,
        ACT_STOP_ALL = 3'd3,
        ACT_FREED    = 3'd4
    } t_action;

    typedef struct packed {
        t_op         op;
        logic [6:0]  note;
        logic [7:0]  velocity;
        logic [2:0]  rslot;
        logic [15:0] level;
    } t_word;

endpackage

// ===== hw/rtl/mva_front.sv =====
// ----------------------------------------------------------------------------
// mva_front
// Input stage: masks absent MIDI bytes, classifies each word into an
// operation and holds it until the queue takes it.
// ----------------------------------------------------------------------------
module mva_front
    import mva_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_cmd,
    input  logic [7:0]  i_status_byte,
    input  logic [7:0]  i_first_data,
    input  logic [7:0]  i_second_data,
    input  logic [1:0]  i_byte_count,
    input  logic [2:0]  i_report_slot,
    input  logic [15:0] i_report_level,
    output logic        o_push,
    output t_word       o_word,
    input  logic        i_q_ready
);

    logic        r_valid;
    t_word       r_word;
    t_word       n_word;
    logic [7:0]  d1;
    logic [7:0]  d2;
    logic [3:0]  nib;
    logic        note_ok;

    always_comb begin
        d1      = (i_byte_count > 2'd1) ? i_first_data : 8'd0;
        d2      = (i_byte_count > 2'd2) ? i_second_data : 8'd0;
        nib     = i_status_byte[7:4];
        note_ok = !d1[7];
        n_word.op       = OP_NONE;
        n_word.note     = d1[6:0];
        n_word.velocity = d2;
        n_word.rslot    = i_report_slot;
        n_word.level    = i_report_level;
        unique case (t_cmd'(i_cmd))
            CMD_MIDI: begin
                if (i_byte_count != 2'd0) begin
                    if ((nib == NIB_NOTE_OFF || (nib == NIB_NOTE_ON && d2 == 8'd0))
                        && note_ok) begin
                        n_word.op = OP_NOTE_OFF;
                    end else if (nib == NIB_NOTE_ON && note_ok) begin
                        n_word.op = OP_NOTE_ON;
                    end else if (nib == NIB_CTRL
                                 && (d1 == CC_SOUND_OFF || d1 == CC_NOTES_OFF)) begin
                        n_word.op = OP_STOP_ALL;
                    end
                end
            end
            CMD_FINISHED: n_word.op = OP_FINISHED;
            CMD_LEVEL:    n_word.op = OP_LEVEL;
            default:      n_word.op = OP_NONE;
        endcase
    end

    assign o_ready = !r_valid || i_q_ready;
    assign o_push  = r_valid && i_q_ready;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_word <= n_word;
        end
    end

endmodule

// ===== hw/rtl/mva_queue.sv =====
// ----------------------------------------------------------------------------
// mva_queue
// Short first-in first-out queue of decoded words between the decoder and
// the voice sequencer.
// ----------------------------------------------------------------------------
module mva_queue
    import mva_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_word i_word,
    output logic  o_ready,
    output logic  o_valid,
    input  logic  i_pop,
    output t_word o_word
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_word         r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_ready = r_cnt != CW'(QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_word  = r_mem[r_rd];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_word;
        end
    end

endmodule

// ===== hw/rtl/mva_back.sv =====
// ----------------------------------------------------------------------------
// mva_back
// Voice sequencer: holds the voice table, scans it one slot per cycle for
// note words, applies the chosen action and registers the result word.
// ----------------------------------------------------------------------------
module mva_back
    import mva_pkg::*;
#(
    parameter int VOICES     = 8,
    parameter int LEVEL_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_word      i_word,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [2:0] o_action,
    output logic [2:0] o_slot,
    output logic [6:0] o_note,
    output logic [7:0] o_velocity,
    output logic       o_stolen,
    output logic       o_retrigger,
    output logic [3:0] o_active_count
);

    localparam int SW = $clog2(VOICES);
    localparam int NW = $clog2(VOICES + 1);
    localparam int RW = (SW + 1 > 4) ? SW + 1 : 4;
    localparam int LW = LEVEL_BITS + 16;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_EXEC = 3'b100
    } t_state;

    t_state                r_state;
    t_word                 r_word;
    logic [SW-1:0]         r_idx;

    logic [VOICES-1:0]     r_active;
    logic [VOICES-1:0]     r_rel;
    logic [6:0]            r_note  [VOICES];
    logic [63:0]           r_age   [VOICES];
    logic [LEVEL_BITS-1:0] r_level [VOICES];
    logic [63:0]           r_age_cnt;
    logic [NW-1:0]         r_cnt;

    logic                  r_has_match;
    logic [SW-1:0]         r_match;
    logic                  r_has_idle;
    logic [SW-1:0]         r_idle;
    logic                  r_has_rel;
    logic [SW-1:0]         r_rel_slot;
    logic [63:0]           r_rel_age;
    logic [SW-1:0]         r_low_slot;
    logic [LEVEL_BITS-1:0] r_low_lvl;

    logic                  r_o_valid;
    t_action               r_o_action;
    logic [2:0]            r_o_slot;
    logic [6:0]            r_o_note;
    logic [7:0]            r_o_vel;
    logic                  r_o_stolen;
    logic                  r_o_retrig;
    logic [3:0]            r_o_count;

    logic                  fire;
    logic [RW-1:0]         rs_ext;
    logic                  rs_ok;
    logic [SW-1:0]         ridx;
    logic [LW-1:0]         lvl_wide;
    logic [LEVEL_BITS-1:0] lvl_scaled;
    logic [SW-1:0]         tgt;
    t_action               n_action;
    logic [SW-1:0]         n_slot;
    logic [6:0]            n_note;
    logic [7:0]            n_vel;
    logic                  n_stolen;
    logic                  n_retrig;
    logic [NW-1:0]         n_cnt;
    logic                  scan_last;

    assign o_pop     = (r_state == S_IDLE) && i_q_valid;
    assign fire      = (r_state == S_EXEC) && (!r_o_valid || i_ready);
    assign scan_last = r_idx == SW'(VOICES - 1);

    assign rs_ext     = RW'(r_word.rslot);
    assign rs_ok      = rs_ext < RW'(VOICES);
    assign ridx       = rs_ext[SW-1:0];
    assign lvl_wide   = {r_word.level, LEVEL_BITS'(0)};
    assign lvl_scaled = lvl_wide[LW-1:16];

    always_comb begin
        tgt      = r_match;
        n_action = ACT_NONE;
        n_slot   = '0;
        n_note   = '0;
        n_vel    = '0;
        n_stolen = 1'b0;
        n_retrig = 1'b0;
        n_cnt    = r_cnt;
        if (!r_has_match) begin
            if (r_has_idle) begin
                tgt = r_idle;
            end else if (r_has_rel) begin
                tgt = r_rel_slot;
            end else begin
                tgt = r_low_slot;
            end
        end
        unique case (r_word.op)
            OP_NOTE_OFF: begin
                if (r_has_match) begin
                    n_action = ACT_RELEASE;
                    n_slot   = r_match;
                    n_note   = r_word.note;
                end
            end
            OP_NOTE_ON: begin
                n_action = ACT_START;
                n_slot   = tgt;
                n_note   = r_word.note;
                n_vel    = r_word.velocity;
                n_retrig = r_has_match;
                n_stolen = !r_has_match && !r_has_idle;
                if (!r_has_match && r_has_idle) begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            OP_STOP_ALL: begin
                n_action = ACT_STOP_ALL;
                n_cnt    = '0;
            end
            OP_FINISHED: begin
                if (rs_ok && r_active[ridx]) begin
                    n_action = ACT_FREED;
                    n_slot   = ridx;
                    n_cnt    = r_cnt - 1'b1;
                end
            end
            default: n_action = ACT_NONE;
        endcase
    end

    // sequencer and voice flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_active  <= '0;
            r_rel     <= '0;
            r_age_cnt <= '0;
            r_cnt     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (r_o_valid && i_ready && !fire) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        if (i_word.op == OP_NOTE_OFF || i_word.op == OP_NOTE_ON) begin
                            r_state <= S_SCAN;
                        end else begin
                            r_state <= S_EXEC;
                        end
                    end
                end
                S_SCAN: begin
                    if (scan_last) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (fire) begin
                        r_state   <= S_IDLE;
                        r_o_valid <= 1'b1;
                        r_cnt     <= n_cnt;
                        unique case (r_word.op)
                            OP_NOTE_OFF: begin
                                if (r_has_match) begin
                                    r_rel[r_match] <= 1'b1;
                                end
                            end
                            OP_NOTE_ON: begin
                                r_active[tgt] <= 1'b1;
                                r_rel[tgt]    <= 1'b0;
                                r_age_cnt     <= r_age_cnt + 64'd1;
                            end
                            OP_STOP_ALL: begin
                                r_active  <= '0;
                                r_rel     <= '0;
                                r_age_cnt <= '0;
                            end
                            OP_FINISHED: begin
                                if (rs_ok) begin
                                    r_active[ridx] <= 1'b0;
                                    r_rel[ridx]    <= 1'b0;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // voice payload, scan trackers and result word
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_word      <= i_word;
            r_idx       <= '0;
            r_has_match <= 1'b0;
            r_has_idle  <= 1'b0;
            r_has_rel   <= 1'b0;
        end
        if (r_state == S_SCAN) begin
            r_idx <= r_idx + 1'b1;
            if (!r_has_match && r_active[r_idx] && r_note[r_idx] == r_word.note) begin
                r_has_match <= 1'b1;
                r_match     <= r_idx;
            end
            if (!r_has_idle && !r_active[r_idx]) begin
                r_has_idle <= 1'b1;
                r_idle     <= r_idx;
            end
            if (r_rel[r_idx] && (!r_has_rel || r_age[r_idx] < r_rel_age)) begin
                r_has_rel  <= 1'b1;
                r_rel_slot <= r_idx;
                r_rel_age  <= r_age[r_idx];
            end
            if (r_idx == '0 || r_level[r_idx] < r_low_lvl) begin
                r_low_slot <= r_idx;
                r_low_lvl  <= r_level[r_idx];
            end
        end
        if (fire) begin
            r_o_action <= n_action;
            r_o_slot   <= 3'(n_slot);
            r_o_note   <= n_note;
            r_o_vel    <= n_vel;
            r_o_stolen <= n_stolen;
            r_o_retrig <= n_retrig;
            r_o_count  <= 4'(n_cnt);
            if (r_word.op == OP_NOTE_ON) begin
                r_note[tgt]  <= r_word.note;
                r_age[tgt]   <= r_age_cnt + 64'd1;
                r_level[tgt] <= '0;
            end
            if (r_word.op == OP_LEVEL && rs_ok && r_active[ridx]) begin
                r_level[ridx] <= lvl_scaled;
            end
        end
    end

    assign o_valid        = r_o_valid;
    assign o_action       = r_o_action;
    assign o_slot         = r_o_slot;
    assign o_note         = r_o_note;
    assign o_velocity     = r_o_vel;
    assign o_stolen       = r_o_stolen;
    assign o_retrigger    = r_o_retrig;
    assign o_active_count = r_o_count;

endmodule

// ===== hw/rtl/midi_voice_allocator.sv =====
// ----------------------------------------------------------------------------
// midi_voice_allocator
// Assigns MIDI notes to a pool of voice slots with retrigger, idle search and
// voice stealing; tracks finished and level reports from the audio side.
//
// channel   handshake           word
// input     i_valid / o_ready   cmd, status, data bytes, byte count, report
// output    o_valid / i_ready   action, slot, note, velocity, flags, count
//
// note on and note off words make the sequencer scan the voice table, one
// slot of the voice table read per cycle; other words go straight to execute.
// the decoder and a two-word queue keep accepting while the sequencer works.
// a full result register stalls the sequencer, never the table state.
// reset clears all voice flags, the age counter and the active count.
// ----------------------------------------------------------------------------
module midi_voice_allocator
    import mva_pkg::*;
#(
    parameter int VOICES     = 8,
    parameter int LEVEL_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_cmd,
    input  logic [7:0]  i_status_byte,
    input  logic [7:0]  i_first_data,
    input  logic [7:0]  i_second_data,
    input  logic [1:0]  i_byte_count,
    input  logic [2:0]  i_report_slot,
    input  logic [15:0] i_report_level,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_action,
    output logic [2:0]  o_slot,
    output logic [6:0]  o_note,
    output logic [7:0]  o_velocity,
    output logic        o_stolen,
    output logic        o_retrigger,
    output logic [3:0]  o_active_count
);

    logic  push;
    t_word front_word;
    logic  q_ready;
    logic  q_valid;
    logic  pop;
    t_word q_word;

    mva_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_cmd          (i_cmd),
        .i_status_byte  (i_status_byte),
        .i_first_data   (i_first_data),
        .i_second_data  (i_second_data),
        .i_byte_count   (i_byte_count),
        .i_report_slot  (i_report_slot),
        .i_report_level (i_report_level),
        .o_push         (push),
        .o_word         (front_word),
        .i_q_ready      (q_ready)
    );

    mva_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_word  (front_word),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_word  (q_word)
    );

    mva_back #(
        .VOICES     (VOICES),
        .LEVEL_BITS (LEVEL_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_word         (q_word),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_action       (o_action),
        .o_slot         (o_slot),
        .o_note         (o_note),
        .o_velocity     (o_velocity),
        .o_stolen       (o_stolen),
        .o_retrigger    (o_retrigger),
        .o_active_count (o_active_count)
    );

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the MIDI voice allocator. A local voice table
// mirrors retrigger, idle search, stealing, finished and level reports; every
// accepted input word queues one predicted result that the checker compares
// field by field. Directed cases come first, then random traffic with random
// gaps on both sides, a long output stall and a full drain pause.
// ----------------------------------------------------------------------------
module tb_top;
    import mva_pkg::*;

    localparam int N_VOICES   = 8;
    localparam int WDOG_LIMIT = 4000;
    localparam int HOLD_LEN   = 400;

    typedef struct {
        t_action    action;
        logic [2:0] slot;
        logic [6:0] note;
        logic [7:0] velocity;
        logic       stolen;
        logic       retrigger;
        logic [3:0] active_count;
    } t_result;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_valid        = 1'b0;
    logic        o_ready;
    logic [1:0]  i_cmd          = '0;
    logic [7:0]  i_status_byte  = '0;
    logic [7:0]  i_first_data   = '0;
    logic [7:0]  i_second_data  = '0;
    logic [1:0]  i_byte_count   = '0;
    logic [2:0]  i_report_slot  = '0;
    logic [15:0] i_report_level = '0;
    logic        o_valid;
    logic        i_ready        = 1'b0;
    logic [2:0]  o_action;
    logic [2:0]  o_slot;
    logic [6:0]  o_note;
    logic [7:0]  o_velocity;
    logic        o_stolen;
    logic        o_retrigger;
    logic [3:0]  o_active_count;

    // voice table mirror
    bit          v_active    [N_VOICES];
    bit          v_releasing [N_VOICES];
    logic [6:0]  v_note      [N_VOICES];
    logic [63:0] v_age       [N_VOICES];
    logic [15:0] v_level     [N_VOICES];
    logic [63:0] age_cnt;

    t_result     pending_results[$];
    int unsigned mismatch_count = 0;
    int unsigned result_index   = 0;
    bit          quiet          = 1'b0;
    int unsigned hold_seq       = 0;
    int unsigned hold_seen      = 0;
    int unsigned rx_stall       = 0;
    int unsigned idle_cycles    = 0;

    midi_voice_allocator #(
        .VOICES     (N_VOICES),
        .LEVEL_BITS (16)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_cmd          (i_cmd),
        .i_status_byte  (i_status_byte),
        .i_first_data   (i_first_data),
        .i_second_data  (i_second_data),
        .i_byte_count   (i_byte_count),
        .i_report_slot  (i_report_slot),
        .i_report_level (i_report_level),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_action       (o_action),
        .o_slot         (o_slot),
        .o_note         (o_note),
        .o_velocity     (o_velocity),
        .o_stolen       (o_stolen),
        .o_retrigger    (o_retrigger),
        .o_active_count (o_active_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic int find_note(logic [6:0] n);
        for (int v = 0; v < N_VOICES; v++) begin
            if (v_active[v] && v_note[v] == n) begin
                return v;
            end
        end
        return -1;
    endfunction

    task automatic clear_voice(int v);
        v_active[v]    = 1'b0;
        v_releasing[v] = 1'b0;
        v_note[v]      = '0;
        v_level[v]     = '0;
    endtask

    task automatic predict_allocation(
        input logic [1:0]  cmd,
        input logic [7:0]  st,
        input logic [7:0]  b1,
        input logic [7:0]  b2,
        input logic [1:0]  cnt,
        input logic [2:0]  rs,
        input logic [15:0] lvl
    );
        t_result     r;
        logic [7:0]  d1;
        logic [7:0]  d2;
        logic [3:0]  nib;
        int          s;
        bit          found;
        logic [63:0] oldest;
        logic [15:0] lowest;
        r.action       = ACT_NONE;
        r.slot         = '0;
        r.note         = '0;
        r.velocity     = '0;
        r.stolen       = 1'b0;
        r.retrigger    = 1'b0;
        r.active_count = '0;
        d1  = (cnt > 2'd1) ? b1 : 8'd0;
        d2  = (cnt > 2'd2) ? b2 : 8'd0;
        nib = st[7:4];
        if (cmd == CMD_MIDI && cnt != 2'd0) begin
            if ((nib == NIB_NOTE_OFF || (nib == NIB_NOTE_ON && d2 == 8'd0)) && d1 <= 8'd127) begin
                s = find_note(d1[6:0]);
                if (s >= 0) begin
                    v_releasing[s] = 1'b1;
                    r.action       = ACT_RELEASE;
                    r.slot         = 3'(s);
                    r.note         = d1[6:0];
                end
            end else if (nib == NIB_NOTE_ON && d1 <= 8'd127) begin
                s = find_note(d1[6:0]);
                if (s >= 0) begin
                    r.retrigger = 1'b1;
                end else begin
                    for (int v = N_VOICES - 1; v >= 0; v--) begin
                        if (!v_active[v]) begin
                            s = v;
                        end
                    end
                    if (s < 0) begin
                        // oldest releasing voice, else quietest voice
                        found  = 1'b0;
                        oldest = '0;
                        for (int v = 0; v < N_VOICES; v++) begin
                            if (v_releasing[v] && (!found || v_age[v] < oldest)) begin
                                oldest = v_age[v];
                                s      = v;
                                found  = 1'b1;
                            end
                        end
                        if (!found) begin
                            lowest = v_level[0];
                            s      = 0;
                            for (int v = 1; v < N_VOICES; v++) begin
                                if (v_level[v] < lowest) begin
                                    lowest = v_level[v];
                                    s      = v;
                                end
                            end
                        end
                        r.stolen = 1'b1;
                    end
                end
                age_cnt        = age_cnt + 64'd1;
                v_active[s]    = 1'b1;
                v_releasing[s] = 1'b0;
                v_note[s]      = d1[6:0];
                v_age[s]       = age_cnt;
                v_level[s]     = '0;
                r.action       = ACT_START;
                r.slot         = 3'(s);
                r.note         = d1[6:0];
                r.velocity     = d2;
            end else if (nib == NIB_CTRL && (d1 == CC_SOUND_OFF || d1 == CC_NOTES_OFF)) begin
                for (int v = 0; v < N_VOICES; v++) begin
                    clear_voice(v);
                end
                age_cnt  = '0;
                r.action = ACT_STOP_ALL;
            end
        end else if (cmd == CMD_FINISHED) begin
            if (v_active[rs]) begin
                clear_voice(rs);
                r.action = ACT_FREED;
                r.slot   = rs;
            end
        end else if (cmd == CMD_LEVEL) begin
            if (v_active[rs]) begin
                v_level[rs] = lvl;
            end
        end
        for (int v = 0; v < N_VOICES; v++) begin
            r.active_count = r.active_count + 4'(v_active[v]);
        end
        pending_results.push_back(r);
    endtask

    task automatic send_word(
        input logic [1:0]  cmd,
        input logic [7:0]  st,
        input logic [7:0]  b1,
        input logic [7:0]  b2,
        input logic [1:0]  cnt,
        input logic [2:0]  rs,
        input logic [15:0] lvl
    );
        int unsigned gap;
        i_valid        <= 1'b1;
        i_cmd          <= cmd;
        i_status_byte  <= st;
        i_first_data   <= b1;
        i_second_data  <= b2;
        i_byte_count   <= cnt;
        i_report_slot  <= rs;
        i_report_level <= lvl;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        predict_allocation(cmd, st, b1, b2, cnt, rs, lvl);
        gap = pick_gap();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_midi(input logic [7:0] st, input logic [7:0] b1,
                             input logic [7:0] b2, input logic [1:0] cnt);
        send_word(CMD_MIDI, st, b1, b2, cnt, 3'($urandom), 16'($urandom));
    endtask

    task automatic send_report(input logic [1:0] cmd, input logic [2:0] rs,
                               input logic [15:0] lvl);
        send_word(cmd, 8'($urandom), 8'($urandom), 8'($urandom), 2'($urandom), rs, lvl);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (pending_results.size() != 0);
    endtask

    task automatic flag_mismatch(string what, int unsigned got, int unsigned want);
        $display("result %0d %s: got %0d expected %0d", result_index, what, got, want);
        mismatch_count++;
    endtask

    task automatic rand_word();
        int unsigned pick;
        logic [7:0]  nt;
        logic [7:0]  vel;
        logic [1:0]  cnt;
        pick = $urandom_range(0, 99);
        nt   = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(60, 71));
        vel  = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom);
        cnt  = ($urandom_range(0, 19) == 0) ? 2'($urandom) : 2'd3;
        if (pick < 38) begin
            send_midi({NIB_NOTE_ON, 4'($urandom)}, nt, vel, cnt);
        end else if (pick < 58) begin
            send_midi({NIB_NOTE_OFF, 4'($urandom)}, nt, 8'($urandom), cnt);
        end else if (pick < 70) begin
            send_report(CMD_FINISHED, 3'($urandom), 16'($urandom));
        end else if (pick < 84) begin
            send_report(CMD_LEVEL, 3'($urandom), 16'($urandom));
        end else if (pick < 87) begin
            send_midi({NIB_CTRL, 4'($urandom)},
                      $urandom_range(0, 1) ? CC_SOUND_OFF : CC_NOTES_OFF, 8'($urandom), cnt);
        end else begin
            send_word(2'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                      2'($urandom), 3'($urandom), 16'($urandom));
        end
    endtask

    task automatic test_directed();
        send_midi(8'h90, 8'd0, 8'd1, 2'd3);
        send_midi(8'h9f, 8'd127, 8'd255, 2'd3);
        // velocity byte absent reads as zero: note off with no voice
        send_midi(8'h93, 8'd60, 8'd77, 2'd2);
        send_midi(8'h90, 8'd60, 8'd100, 2'd3);
        send_midi(8'h91, 8'd60, 8'd50, 2'd3);
        send_midi(8'h90, 8'd200, 8'd10, 2'd3);
        send_midi(8'h80, 8'd255, 8'd0, 2'd3);
        for (int n = 61; n <= 65; n++) begin
            send_midi(8'h90, 8'(n), 8'h40, 2'd3);
        end
        send_report(CMD_LEVEL, 3'd0, 16'hffff);
        // pool full, nothing releasing: quietest voice goes
        send_midi(8'h90, 8'd70, 8'd90, 2'd3);
        send_midi(8'h9e, 8'd0, 8'd0, 2'd3);
        send_midi(8'h8a, 8'd60, 8'd33, 2'd3);
        // oldest releasing voice goes
        send_midi(8'h90, 8'd71, 8'd91, 2'd3);
        send_midi(8'h80, 8'd60, 8'd0, 2'd3);
        send_report(CMD_FINISHED, 3'd2, 16'h0000);
        send_report(CMD_FINISHED, 3'd2, 16'h1234);
        send_word(CMD_UNUSED, 8'h90, 8'd10, 8'd10, 2'd3, 3'd7, 16'hffff);
        send_midi(8'h90, 8'd10, 8'd10, 2'd0);
        send_midi(8'ha0, 8'd61, 8'd10, 2'd3);
        send_midi(8'hb0, 8'd120, 8'd0, 2'd1);
        send_midi(8'hb5, 8'd64, 8'd127, 2'd3);
        send_midi(8'hbf, 8'd120, 8'd0, 2'd3);
        send_report(CMD_LEVEL, 3'd7, 16'hffff);
        send_midi(8'h90, 8'd5, 8'd5, 2'd3);
        send_midi(8'hb0, 8'd123, 8'd0, 2'd3);
        wait_drained();
    endtask

    task automatic test_random();
        for (int chunk = 0; chunk < 8; chunk++) begin
            quiet = (chunk % 4 == 3);
            repeat (100) rand_word();
        end
        quiet = 1'b0;
        wait_drained();
    endtask

    task automatic test_output_stall();
        quiet    = 1'b1;
        hold_seq = hold_seq + 1;
        repeat (24) rand_word();
        quiet = 1'b0;
        wait_drained();
    endtask

    task automatic test_input_pause();
        repeat (30) rand_word();
        wait_drained();
        repeat (30) rand_word();
        wait_drained();
    endtask

    // output side
    always @(posedge i_clk) begin
        if (hold_seen != hold_seq) begin
            hold_seen <= hold_seq;
            rx_stall  <= HOLD_LEN;
            i_ready   <= 1'b0;
        end else if (rx_stall != 0) begin
            rx_stall <= rx_stall - 1;
            i_ready  <= 1'b0;
        end else begin
            rx_stall <= pick_gap();
            i_ready  <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_result w;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                flag_mismatch("unexpected word, action", o_action, ACT_NONE);
            end else begin
                w = pending_results.pop_front();
                if (o_action !== w.action) flag_mismatch("action", o_action, w.action);
                if (o_slot !== w.slot) flag_mismatch("slot", o_slot, w.slot);
                if (o_note !== w.note) flag_mismatch("note", o_note, w.note);
                if (o_velocity !== w.velocity) flag_mismatch("velocity", o_velocity, w.velocity);
                if (o_stolen !== w.stolen) flag_mismatch("stolen", o_stolen, w.stolen);
                if (o_retrigger !== w.retrigger) begin
                    flag_mismatch("retrigger", o_retrigger, w.retrigger);
                end
                if (o_active_count !== w.active_count) begin
                    flag_mismatch("active_count", o_active_count, w.active_count);
                end
            end
            result_index++;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        for (int v = 0; v < N_VOICES; v++) begin
            clear_voice(v);
            v_age[v] = '0;
        end
        age_cnt = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        test_output_stall();
        test_input_pause();
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== midi_voice_allocator.f =====
hw/rtl/mva_pkg.sv
hw/rtl/mva_front.sv
hw/rtl/mva_queue.sv
hw/rtl/mva_back.sv
hw/rtl/midi_voice_allocator.sv
sim/tb_top.sv
